@@ rtl/rgbconv_pkg.sv @@
// types, register codes and constants shared by the rgb convolution block
package rgbconv_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int COEFF_BITS_DEF = 16;

  localparam int KROW_W    = 48;
  localparam int CFG_IDX_W = 3;
  localparam int WREG_W    = 12;
  localparam int HREG_W    = 16;
  localparam int PIX_W     = 24;

  localparam int OUT_DEPTH = 8;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KTOP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KMID   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KBOT   = 3'd4;

  localparam logic [WREG_W-1:0] WIDTH_RST  = 12'd2048;
  localparam logic [HREG_W-1:0] HEIGHT_RST = 16'd1;
  localparam logic [KROW_W-1:0] KTOP_RST   = 48'd0;
  localparam logic [KROW_W-1:0] KMID_RST   = 48'h0000_0001_0000;
  localparam logic [KROW_W-1:0] KBOT_RST   = 48'd0;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] rgb_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       end_of_row;
    logic       end_of_frame;
    logic       last_in_run;
  } res_t;

endpackage

@@ rtl/rgb_convolution_clamp_edge.sv @@
// 3x3 rgb convolution with replicated borders over two line stores, clamped to 8 bits
//
//  channel | handshake            | payload
//  pix     | pix_valid/pix_ready  | pix_t: operation, red_in, green_in, blue_in
//  res     | res_valid/res_ready  | res_t: filtered rgb, end_of_row, end_of_frame, last_in_run
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// one pixel per clock while queue credits last; a pixel closing a row, past the first row
// and column, gives two results through the single nine-tap datapath and holds the input
// while the second issues; a transfer passes stage 1, stage 2, products and sums to the queue
// line stores are plain memories read at two ports and need no clearing after reset
// synchronous reset clears counters, registers and queue; the 8-entry result queue
// absorbs output stalls and pix_ready drops when its credits run out
module rgb_convolution_clamp_edge
  import rgbconv_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int COEFF_BITS = COEFF_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_ready,
  input  pix_t                 pix,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KROW_W-1:0]    cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = COEFF_BITS + 9;
  localparam int SW = PW + 4;

  // configuration
  logic [WREG_W-1:0]            width_reg;
  logic [HREG_W-1:0]            height_reg;
  logic [2:0][KROW_W-1:0]       krow;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RST;
      height_reg <= HEIGHT_RST;
      krow[0]    <= KTOP_RST;
      krow[1]    <= KMID_RST;
      krow[2]    <= KBOT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_reg  <= cfg_data[WREG_W-1:0];
        CFG_HEIGHT: height_reg <= cfg_data[HREG_W-1:0];
        CFG_KTOP:   krow[0]    <= cfg_data;
        CFG_KMID:   krow[1]    <= cfg_data;
        CFG_KBOT:   krow[2]    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [WW-1:0]     w_eff;
  logic [HREG_W-1:0] h_eff;

  always_comb begin
    if (width_reg == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_reg) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_reg);
    end
    h_eff = (height_reg == '0) ? HREG_W'(1) : height_reg;
  end

  // frame counters and input decode
  logic [HREG_W-1:0] row_cnt;
  logic [CW-1:0]     col_cnt;
  logic [CW-1:0]     drain_cnt;
  logic [CNT_W-1:0]  resv;
  logic              fe;
  logic              acc;
  logic              is_drain, take, px_rowend, dr_last, first;
  logic              has_a, has_b, a_end;
  logic [CW-1:0]     addr_a, addr_b;
  logic [1:0]        nres;

  always_comb begin
    acc       = pix_valid && pix_ready;
    is_drain  = (pix.operation == OP_DRAIN);
    px_rowend = (WW'(col_cnt) + WW'(1)) >= w_eff;
    dr_last   = (WW'(drain_cnt) + WW'(1)) >= w_eff;
    take      = is_drain ? (row_cnt != '0 && row_cnt >= h_eff) : (row_cnt < h_eff);
    first     = is_drain ? (drain_cnt == '0) : (col_cnt == '0);
    has_a     = is_drain || (row_cnt != '0 && col_cnt != '0);
    has_b     = !is_drain && row_cnt != '0 && px_rowend;
    a_end     = is_drain && dr_last;
    addr_a    = is_drain ? drain_cnt : col_cnt;
    addr_b    = dr_last ? drain_cnt : drain_cnt + CW'(1);
    nres      = take ? ({1'b0, has_a} + {1'b0, has_b}) : 2'd0;
  end

  assign pix_ready = fe && (resv <= CNT_W'(OUT_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt   <= '0;
      col_cnt   <= '0;
      drain_cnt <= '0;
    end else if (acc && take) begin
      if (is_drain) begin
        if (dr_last) begin
          row_cnt   <= '0;
          col_cnt   <= '0;
          drain_cnt <= '0;
        end else begin
          drain_cnt <= drain_cnt + CW'(1);
        end
      end else if (px_rowend) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + HREG_W'(1);
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  // stage 1: line store data, window update and write-back
  logic          s1_valid, s1_drain, s1_first, s1_r1, s1_r2;
  logic          s1_has_a, s1_has_b, s1_a_end;
  rgb_t          s1_pix;
  logic [CW-1:0] s1_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (fe) begin
      s1_valid <= acc && take;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_drain <= is_drain;
      s1_first <= first;
      s1_r1    <= row_cnt != '0;
      s1_r2    <= row_cnt >= HREG_W'(2);
      s1_has_a <= has_a;
      s1_has_b <= has_b;
      s1_a_end <= a_end;
      s1_pix   <= {pix.red_in, pix.green_in, pix.blue_in};
      s1_col   <= addr_a;
    end
  end

  rgb_t newer_mem [MAX_WIDTH];
  rgb_t older_mem [MAX_WIDTH];
  rgb_t na_q, nb_q, oa_q, ob_q;
  rgb_t fwd_n, fwd_o;
  logic hit_na, hit_nb, hit_oa, hit_ob;
  logic n_we, o_we;
  rgb_t na, nb, oa, ob, mid, top;
  rgb_t va [3];
  rgb_t vb [3];

  always_comb begin
    na   = hit_na ? fwd_n : na_q;
    nb   = hit_nb ? fwd_n : nb_q;
    oa   = hit_oa ? fwd_o : oa_q;
    ob   = hit_ob ? fwd_o : ob_q;
    mid  = s1_r1 ? na : s1_pix;
    top  = s1_r2 ? oa : mid;
    n_we = fe && s1_valid && !s1_drain;
    o_we = n_we && s1_r1;
    if (s1_drain) begin
      va[0] = s1_r2 ? oa : na;
      vb[0] = s1_r2 ? ob : nb;
      va[1] = na;
      vb[1] = nb;
      va[2] = na;
      vb[2] = nb;
    end else begin
      va[0] = top;
      vb[0] = top;
      va[1] = mid;
      vb[1] = mid;
      va[2] = s1_pix;
      vb[2] = s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      newer_mem[s1_col] <= s1_pix;
    end
    if (acc) begin
      na_q <= newer_mem[addr_a];
      nb_q <= newer_mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (o_we) begin
      older_mem[s1_col] <= mid;
    end
    if (acc) begin
      oa_q <= older_mem[addr_a];
      ob_q <= older_mem[addr_b];
    end
  end

  // forwarding of the write that lands on the edge of a read
  always_ff @(posedge clk) begin
    if (acc) begin
      hit_na <= n_we && (s1_col == addr_a);
      hit_nb <= n_we && (s1_col == addr_b);
      hit_oa <= o_we && (s1_col == addr_a);
      hit_ob <= o_we && (s1_col == addr_b);
      fwd_n  <= s1_pix;
      fwd_o  <= mid;
    end
  end

  logic [2:0][2:0][PIX_W-1:0] win;

  always_ff @(posedge clk) begin
    if (fe && s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= s1_first ? va[i] : win[i][1];
        win[i][1] <= s1_first ? va[i] : win[i][2];
        win[i][2] <= vb[i];
      end
    end
  end

  // stage 2: job issue, a second job holds the front while it issues
  logic s2_valid, s2_has_a, s2_has_b, s2_a_end, s2_second;
  logic job_v, sel_b, job_eor, job_eof, job_last;
  logic [2:0][2:0][PIX_W-1:0] jpx;

  assign fe = !(s2_valid && s2_has_a && s2_has_b && !s2_second);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s2_second <= 1'b0;
    end else begin
      s2_second <= !fe;
      if (fe) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      s2_has_a <= s1_has_a;
      s2_has_b <= s1_has_b;
      s2_a_end <= s1_a_end;
    end
  end

  always_comb begin
    job_v    = s2_valid && (s2_has_a || s2_has_b);
    sel_b    = s2_second || !s2_has_a;
    job_eor  = sel_b ? 1'b1 : s2_a_end;
    job_eof  = sel_b ? 1'b0 : s2_a_end;
    job_last = sel_b ? 1'b1 : !s2_has_b;
    for (int i = 0; i < 3; i++) begin
      jpx[i][0] = sel_b ? win[i][1] : win[i][0];
      jpx[i][1] = sel_b ? win[i][2] : win[i][1];
      jpx[i][2] = win[i][2];
    end
  end

  // multiply, sum, clamp
  logic                 m_valid, m_eor, m_eof, m_last;
  logic                 a_valid, a_eor, a_eof, a_last;
  logic signed [PW-1:0] prod [3][3][3];
  logic signed [SW-1:0] sum_next [3];
  logic signed [SW-1:0] sums [3];
  logic [7:0]           clamped [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      a_valid <= 1'b0;
    end else begin
      m_valid <= job_v;
      a_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    m_eor  <= job_eor;
    m_eof  <= job_eof;
    m_last <= job_last;
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[ch][i][j] <= $signed(krow[i][j*COEFF_BITS +: COEFF_BITS])
                            * $signed({1'b0, jpx[i][j][16-8*ch +: 8]});
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_next[ch] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          sum_next[ch] = sum_next[ch] + SW'(prod[ch][i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    a_eor  <= m_eor;
    a_eof  <= m_eof;
    a_last <= m_last;
    for (int ch = 0; ch < 3; ch++) begin
      sums[ch] <= sum_next[ch];
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (sums[ch][SW-1]) begin
        clamped[ch] = 8'd0;
      end else if (|sums[ch][SW-2:8]) begin
        clamped[ch] = 8'hFF;
      end else begin
        clamped[ch] = sums[ch][7:0];
      end
    end
  end

  // result queue with credits taken at acceptance
  res_t             fifo_q [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             out_xfer;

  assign out_xfer  = res_valid && res_ready;
  assign res_valid = (cnt != '0);
  assign res       = fifo_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (a_valid) begin
      fifo_q[wr_ptr] <= '{red_out: clamped[0], green_out: clamped[1], blue_out: clamped[2],
                          end_of_row: a_eor, end_of_frame: a_eof, last_in_run: a_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
      resv   <= '0;
    end else begin
      if (a_valid) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      cnt  <= cnt + CNT_W'(a_valid) - CNT_W'(out_xfer);
      resv <= resv + (acc ? CNT_W'(nres) : CNT_W'(0)) - CNT_W'(out_xfer);
    end
  end

  a_queue_in_credit: assert property (@(posedge clk) disable iff (rst)
    cnt <= resv) else $error("result queue holds more than was reserved");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    resv <= CNT_W'(OUT_DEPTH)) else $error("reserved results exceed queue depth");

  a_second_job: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_has_a && s2_has_b && !s2_second) |=> (s2_second && m_valid))
    else $error("second result of a row end not issued");

  a_stall_no_take: assert property (@(posedge clk) disable iff (rst)
    s2_second |-> $stable(win)) else $error("window moved during second job");

endmodule

@@ tb/sv/tb_rgb_convolution_clamp_edge.sv @@
// self-checking testbench for the 3x3 rgb convolution with replicated borders
module tb_rgb_convolution_clamp_edge;
  import rgbconv_pkg::*;

  localparam int  LIMIT_CYCLES = 3_000_000;
  localparam int  MAXW         = MAX_WIDTH_DEF;
  localparam int  RAND_ITEMS   = 1200;

  typedef rgb_t nbhd_t [9];

  typedef struct {
    pix_t p;
    int   nexp;
    res_t e0;
    res_t e1;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 pix_valid;
  logic                 pix_ready;
  pix_t                 pix;
  logic                 res_valid;
  logic                 res_ready;
  res_t                 res;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [KROW_W-1:0]    cfg_data;

  rgb_convolution_clamp_edge u_dut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // filter model state
  rgb_t              older_row [MAXW];
  rgb_t              newer_row [MAXW];
  rgb_t              win [9];
  int unsigned       row_cnt;
  int unsigned       col_cnt;
  int unsigned       drn_cnt;
  logic [WREG_W-1:0] width_reg;
  logic [HREG_W-1:0] height_reg;
  logic [KROW_W-1:0] krow [3];

  res_t   filtered_q [$];
  int     errors;
  int     cycles;
  int     items;
  int     send_idle;
  int     recv_idle;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && res_ready) begin
      if (filtered_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", res);
      end else begin
        want = filtered_q.pop_front();
        if (res !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: rgb exp %h %h %h got %h %h %h, eor %b/%b eof %b/%b lir %b/%b",
                     want.red_out, want.green_out, want.blue_out,
                     res.red_out, res.green_out, res.blue_out,
                     want.end_of_row, res.end_of_row, want.end_of_frame, res.end_of_frame,
                     want.last_in_run, res.last_in_run);
        end
      end
    end
  end

  function automatic longint coef(int i, int j);
    logic signed [15:0] c;
    c = krow[i][j*16 +: 16];
    return longint'(c);
  endfunction

  function automatic res_t convolve(nbhd_t px, logic eor, logic eof);
    res_t   o;
    longint sum;
    logic [7:0] ch [3];
    for (int k = 0; k < 3; k++) begin
      sum = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          sum += coef(i, j) * longint'(px[i*3+j][16-8*k +: 8]);
      if (sum < 0) sum = 0;
      if (sum > 255) sum = 255;
      ch[k] = sum[7:0];
    end
    o = '{red_out: ch[0], green_out: ch[1], blue_out: ch[2],
          end_of_row: eor, end_of_frame: eof, last_in_run: 1'b0};
    return o;
  endfunction

  function automatic nbhd_t window_cols(int a, int b, int c);
    nbhd_t px;
    for (int i = 0; i < 3; i++) begin
      px[i*3+0] = win[i*3+a];
      px[i*3+1] = win[i*3+b];
      px[i*3+2] = win[i*3+c];
    end
    return px;
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAXW) return MAXW;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  task automatic filter_step(input pix_t p, output res_t o [2], output int n);
    int unsigned w, h, c, r, d, cl, cr, cc;
    rgb_t  v, top, mid, cur;
    nbhd_t px;
    logic  last;
    w = eff_width();
    h = eff_height();
    cur = {p.red_in, p.green_in, p.blue_in};
    n = 0;
    if (p.operation == OP_PIXEL) begin
      c = col_cnt;
      r = row_cnt;
      if (r >= h) return;
      top = cur;
      mid = cur;
      if (r >= 1) begin
        mid = newer_row[c];
        top = (r >= 2) ? older_row[c] : mid;
        older_row[c] = mid;
      end
      newer_row[c] = cur;
      for (int i = 0; i < 3; i++) begin
        v = (i == 0) ? top : (i == 1) ? mid : cur;
        if (c == 0) begin
          win[i*3+0] = v;
          win[i*3+1] = v;
        end else begin
          win[i*3+0] = win[i*3+1];
          win[i*3+1] = win[i*3+2];
        end
        win[i*3+2] = v;
      end
      if (r >= 1) begin
        if (c >= 1) begin
          o[n] = convolve(window_cols(0, 1, 2), 1'b0, 1'b0);
          n++;
        end
        if (c + 1 >= w) begin
          o[n] = convolve(window_cols(1, 2, 2), 1'b1, 1'b0);
          n++;
        end
      end
      if (c + 1 >= w) begin
        col_cnt = 0;
        row_cnt = r + 1;
      end else begin
        col_cnt = c + 1;
      end
    end else begin
      d = drn_cnt;
      if (row_cnt < h || row_cnt == 0) return;
      last = (d + 1 >= w);
      cl = (d > 0) ? d - 1 : 0;
      cr = last ? d : d + 1;
      for (int j = 0; j < 3; j++) begin
        cc = (j == 0) ? cl : (j == 1) ? d : cr;
        px[j]   = (row_cnt >= 2) ? older_row[cc] : newer_row[cc];
        px[3+j] = newer_row[cc];
        px[6+j] = newer_row[cc];
      end
      o[0] = convolve(px, last, last);
      n = 1;
      if (last) begin
        row_cnt = 0;
        col_cnt = 0;
        drn_cnt = 0;
      end else begin
        drn_cnt = d + 1;
      end
    end
    if (n > 0) o[n-1].last_in_run = 1'b1;
  endtask

  // drive one input transfer; returns at the falling edge after acceptance
  task automatic send_pixel(input pix_t p, output res_t o [2], output int n);
    while ($urandom_range(99) < send_idle) begin
      pix_valid = 1'b0;
      pix = pix_t'($urandom);
      @(negedge clk);
    end
    pix_valid = 1'b1;
    pix = p;
    do @(posedge clk); while (!pix_ready);
    filter_step(p, o, n);
    items++;
    @(negedge clk);
    pix_valid = 1'b0;
  endtask

  task automatic push_checked(input pix_t p);
    res_t o [2];
    int   n;
    send_pixel(p, o, n);
    for (int i = 0; i < n; i++) filtered_q.push_back(o[i]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KROW_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WIDTH:  width_reg  = val[WREG_W-1:0];
      CFG_HEIGHT: height_reg = val[HREG_W-1:0];
      CFG_KTOP:   krow[0]    = val;
      CFG_KMID:   krow[1]    = val;
      CFG_KBOT:   krow[2]    = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic settle();
    while (filtered_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic pix_t mk_pix(logic op, rgb_t v);
    return pix_t'({op, v});
  endfunction

  function automatic pix_t rand_pix();
    return mk_pix(OP_PIXEL, rgb_t'($urandom));
  endfunction

  function automatic logic [KROW_W-1:0] rand_krow();
    logic [KROW_W-1:0] k;
    logic signed [15:0] c;
    for (int j = 0; j < 3; j++) begin
      if ($urandom_range(3) == 0) c = 16'($urandom);
      else c = 16'($urandom_range(8)) - 16'sd4;
      k[j*16 +: 16] = c;
    end
    return k;
  endfunction

  task automatic run_frame(input logic [WREG_W-1:0] w, input logic [HREG_W-1:0] h,
                           input logic [KROW_W-1:0] kt, input logic [KROW_W-1:0] km,
                           input logic [KROW_W-1:0] kb);
    int unsigned ew, eh;
    settle();
    write_reg(CFG_WIDTH, KROW_W'(w));
    write_reg(CFG_HEIGHT, KROW_W'(h));
    write_reg(CFG_KTOP, kt);
    write_reg(CFG_KMID, km);
    write_reg(CFG_KBOT, kb);
    ew = eff_width();
    eh = eff_height();
    for (int r = 0; r < eh; r++)
      for (int c = 0; c < ew; c++) begin
        if ($urandom_range(99) < 3) push_checked(mk_pix(OP_DRAIN, rgb_t'($urandom)));
        push_checked(rand_pix());
      end
    if ($urandom_range(99) < 20) push_checked(rand_pix());
    for (int d = 0; d < ew; d++) push_checked(mk_pix(OP_DRAIN, rgb_t'($urandom)));
  endtask

  function automatic dir_row_t drow(logic op, rgb_t v, int nexp, res_t e0, res_t e1);
    dir_row_t t;
    t.p = mk_pix(op, v);
    t.nexp = nexp;
    t.e0 = e0;
    t.e1 = e1;
    return t;
  endfunction

  initial begin
    localparam rgb_t PA = 24'hFF_FF_FF, PB = 24'h00_00_00, PC = 24'h80_01_FE;
    localparam rgb_t PD = 24'h7F_FE_01, PE = 24'h12_34_56, PF = 24'hAB_CD_EF;
    localparam logic [KROW_W-1:0] KMAX = 48'h7FFF_7FFF_7FFF, KMIN = 48'h8000_8000_8000;
    dir_row_t dir_tbl [11];
    res_t     o [2];
    int       n;
    int       frame;

    rst = 1'b1;
    pix_valid = 1'b0;
    pix = '0;
    res_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    items = 0;
    send_idle = 33;
    recv_idle = 54;
    row_cnt = 0;
    col_cnt = 0;
    drn_cnt = 0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    width_reg = WIDTH_RST;
    height_reg = HEIGHT_RST;
    krow[0] = KTOP_RST;
    krow[1] = KMID_RST;
    krow[2] = KBOT_RST;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // identity kernel, 3x2 frame, with ignored drain and ignored pixel
    write_reg(CFG_WIDTH, 48'd3);
    write_reg(CFG_HEIGHT, 48'd2);
    dir_tbl = '{
      drow(OP_DRAIN, PA, 0, '0, '0),
      drow(OP_PIXEL, PA, 0, '0, '0),
      drow(OP_PIXEL, PB, 0, '0, '0),
      drow(OP_PIXEL, PC, 0, '0, '0),
      drow(OP_PIXEL, PD, 0, '0, '0),
      drow(OP_PIXEL, PE, 1, res_t'({PA, 3'b001}), '0),
      drow(OP_PIXEL, PF, 2, res_t'({PB, 3'b000}), res_t'({PC, 3'b101})),
      drow(OP_PIXEL, PA, 0, '0, '0),
      drow(OP_DRAIN, PB, 1, res_t'({PD, 3'b001}), '0),
      drow(OP_DRAIN, PB, 1, res_t'({PE, 3'b001}), '0),
      drow(OP_DRAIN, PB, 1, res_t'({PF, 3'b111}), '0)
    };
    foreach (dir_tbl[i]) begin
      send_pixel(dir_tbl[i].p, o, n);
      if (dir_tbl[i].nexp > 0) filtered_q.push_back(dir_tbl[i].e0);
      if (dir_tbl[i].nexp > 1) filtered_q.push_back(dir_tbl[i].e1);
    end

    run_frame(12'd0, 16'd0, KMAX, KMAX, KMAX);
    run_frame(12'd1, 16'd1, KMIN, KMIN, KMIN);
    run_frame(12'd5, 16'd4, KMAX, KMIN, KMAX);
    frame = 0;
    while (items < RAND_ITEMS) begin
      if (items < RAND_ITEMS / 3) begin
        send_idle = 33;
        recv_idle = 54;
      end else if (items < 2 * RAND_ITEMS / 3) begin
        send_idle = 54;
        recv_idle = 33;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      run_frame(($urandom_range(9) == 0) ? 12'($urandom_range(13, 40))
                                         : 12'($urandom_range(1, 12)),
                16'($urandom_range(1, 6)), rand_krow(), rand_krow(), rand_krow());
      frame++;
    end

    while (filtered_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rgbconv_pkg.sv
rtl/rgb_convolution_clamp_edge.sv
tb/sv/tb_rgb_convolution_clamp_edge.sv
